FILE: rtl/modulated_fractional_delay_defines.svh
// Assertion macros for the modulated fractional delay.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef MODULATED_FRACTIONAL_DELAY_DEFINES_SVH
`define MODULATED_FRACTIONAL_DELAY_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define MFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("modulated_fractional_delay: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("modulated_fractional_delay: next-cycle check failed");

`else

`define MFD_ASSERT_NOW(label, ante, cons)
`define MFD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/mfd_pkg.sv
`default_nettype none

package mfd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 21;
    localparam int DEPTH_W    = 18;
    localparam int PHASE_W    = 32;
    localparam int SINE_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd2;

    typedef struct packed {
        logic capture;
        logic calc_sidx;
        logic read_sine;
        logic calc_lfo;
        logic calc_total;
        logic calc_addr;
        logic read_b;
        logic take_a;
        logic take_b;
        logic calc_prod;
        logic commit;
        logic load_out;
    } mfd_cmd_t;

    typedef struct packed {
        logic bypass;
    } mfd_status_t;

endpackage

`default_nettype wire

FILE: rtl/mfd_datapath.sv
`default_nettype none

module mfd_datapath
    import mfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 8192,
    parameter int CHANNELS     = 2,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic                       s_channel,
    input  mfd_cmd_t                   cmd,
    output mfd_status_t                status,
    output logic signed [SAMPLE_W-1:0] m_sample_out
);

    localparam int PTR_W       = $clog2(BUFFER_DEPTH);
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W      = CH_W + PTR_W;
    localparam int STORE_DEPTH = CHANNELS << PTR_W;
    localparam int SIDX_W      = $clog2(SINE_ENTRIES);
    localparam int MUL_W       = PHASE_W + SIDX_W + 1;
    localparam int LFO_W       = DEPTH_W + SINE_W + 1;
    localparam int LFO_SH_W    = LFO_W - (SINE_W - 1);
    localparam int TOT_W       = (PTR_W + 9 > 23) ? PTR_W + 9 : 23;
    localparam int PROD_W      = SAMPLE_W + FRAC_W + 2;
    localparam int ACC_W       = PROD_W + 1;

    localparam logic signed [TOT_W-1:0] MAX_TOTAL = TOT_W'((BUFFER_DEPTH - 2) * 256);
    localparam logic [PTR_W:0]          DEPTH_EXT = (PTR_W + 1)'(BUFFER_DEPTH);

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // 32767*sin(2*pi*k/SINE_ENTRIES), Taylor series in Q30, folded at elaboration
    function automatic logic signed [SINE_W-1:0] fixed_sine(input int unsigned k);
        logic [63:0]        u;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [1:0]         quad;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        u    = (64'(k) << 32) / 64'(SINE_ENTRIES);
        quad = u[31:30];
        r    = u & (Q30_ONE - 64'd1);
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (v > 64'sd32767) begin
            v = 64'sd32767;
        end
        if (quad[1]) begin
            v = -v;
        end
        return v[SINE_W-1:0];
    endfunction

    logic signed [SINE_W-1:0] sine_rom [SINE_ENTRIES];

    for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_sine
        assign sine_rom[gi] = fixed_sine(32'(gi));
    end

    // configuration
    logic [DELAY_W-1:0] delay_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [PHASE_W-1:0] step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
            depth_reg <= '0;
            step_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_DELAY: begin
                    delay_reg <= cfg_data[DELAY_W-1:0];
                end
                REG_DEPTH: begin
                    depth_reg <= cfg_data[DEPTH_W-1:0];
                end
                REG_STEP: begin
                    step_reg <= cfg_data[PHASE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign status.bypass = delay_reg < DELAY_W'(1 << FRAC_W);

    // per-channel state; wrap marks a channel whose store has been filled once
    logic [PTR_W-1:0]   ptr_reg   [CHANNELS];
    logic [PHASE_W-1:0] phase_reg [CHANNELS];
    logic               wrap_reg  [CHANNELS];

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CH_W-1:0]            ch_reg;
    logic                       byp_reg;

    logic [PTR_W-1:0]   ptr_cur;
    logic [PHASE_W-1:0] phase_cur;
    logic               wrap_cur;
    logic [PTR_W:0]     ptr_plus;
    logic               ptr_wrap;
    logic [PTR_W-1:0]   ptr_next;

    assign ptr_cur   = ptr_reg[ch_reg];
    assign phase_cur = phase_reg[ch_reg];
    assign wrap_cur  = wrap_reg[ch_reg];
    assign ptr_plus  = {1'b0, ptr_cur} + (PTR_W + 1)'(1);
    assign ptr_wrap  = (ptr_plus == DEPTH_EXT);
    assign ptr_next  = ptr_wrap ? '0 : ptr_plus[PTR_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_sample_in;
            ch_reg     <= (CHANNELS == 1) ? '0 : CH_W'(s_channel);
            byp_reg    <= status.bypass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                ptr_reg[i]   <= '0;
                phase_reg[i] <= '0;
                wrap_reg[i]  <= 1'b0;
            end
        end else if (cmd.commit) begin
            ptr_reg[ch_reg]   <= ptr_next;
            phase_reg[ch_reg] <= phase_cur + step_reg;
            wrap_reg[ch_reg]  <= wrap_cur | ptr_wrap;
        end
    end

    // LFO: sine index, table read, depth scaling
    logic [MUL_W-1:0]          phase_mul_next;
    logic [SIDX_W-1:0]         sidx_reg;
    logic signed [SINE_W-1:0]  sine_reg;
    logic signed [LFO_W-1:0]   lfo_prod_next;
    logic signed [LFO_W-1:0]   lfo_prod_reg;

    assign phase_mul_next = MUL_W'(phase_cur) * MUL_W'(SINE_ENTRIES);
    assign lfo_prod_next  = $signed({1'b0, depth_reg}) * sine_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc_sidx) begin
            sidx_reg <= phase_mul_next[PHASE_W +: SIDX_W];
        end
        if (cmd.read_sine) begin
            sine_reg <= sine_rom[sidx_reg];
        end
        if (cmd.calc_lfo) begin
            lfo_prod_reg <= lfo_prod_next;
        end
    end

    // total distance, saturated to the usable span
    logic signed [LFO_SH_W-1:0] lfo_next;
    logic signed [TOT_W-1:0]    total_next;
    logic signed [TOT_W-1:0]    total_sat;
    logic [PTR_W-1:0]           d_reg;
    logic [FRAC_W-1:0]          f_reg;

    assign lfo_next   = LFO_SH_W'(lfo_prod_reg >>> (SINE_W - 1));
    assign total_next = TOT_W'($signed({1'b0, delay_reg})) + TOT_W'(lfo_next);

    always_comb begin
        total_sat = total_next;
        if (total_next < 0) begin
            total_sat = '0;
        end else if (total_next > MAX_TOTAL) begin
            total_sat = MAX_TOTAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_total) begin
            d_reg <= total_sat[FRAC_W +: PTR_W];
            f_reg <= total_sat[FRAC_W-1:0];
        end
    end

    // tap addresses behind the write pointer
    logic [PTR_W:0]   d_ext;
    logic [PTR_W:0]   d1_ext;
    logic [PTR_W:0]   ptr_ext;
    logic [PTR_W:0]   ia_w;
    logic [PTR_W:0]   ib_w;
    logic [PTR_W-1:0] ia_reg;
    logic [PTR_W-1:0] ib_reg;
    logic             va_reg;
    logic             vb_reg;

    assign d_ext   = {1'b0, d_reg};
    assign d1_ext  = d_ext + (PTR_W + 1)'(1);
    assign ptr_ext = {1'b0, ptr_cur};
    assign ia_w    = (ptr_ext < d_ext)  ? ptr_ext + DEPTH_EXT - d_ext  : ptr_ext - d_ext;
    assign ib_w    = (ptr_ext < d1_ext) ? ptr_ext + DEPTH_EXT - d1_ext : ptr_ext - d1_ext;

    always_ff @(posedge aclk) begin
        if (cmd.calc_addr) begin
            ia_reg <= ia_w[PTR_W-1:0];
            ib_reg <= ib_w[PTR_W-1:0];
            // slots not yet written since reset read as zero
            va_reg <= wrap_cur || (ia_w[PTR_W-1:0] < ptr_cur);
            vb_reg <= wrap_cur || (ib_w[PTR_W-1:0] < ptr_cur);
        end
    end

    // sample store, one read and one write port
    logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;

    assign rd_addr = {ch_reg, (cmd.read_b ? ib_reg : ia_reg)};
    assign wr_addr = {ch_reg, ptr_cur};

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            store_mem[wr_addr] <= sample_reg;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // linear interpolation
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] b_reg;
    logic [FRAC_W:0]            wa;
    logic signed [PROD_W-1:0]   pa_next;
    logic signed [PROD_W-1:0]   pb_next;
    logic signed [PROD_W-1:0]   pa_reg;
    logic signed [PROD_W-1:0]   pb_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    assign wa       = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, f_reg};
    assign pa_next  = $signed({1'b0, wa}) * a_reg;
    assign pb_next  = $signed({1'b0, f_reg}) * b_reg;
    assign acc_next = ACC_W'(pa_reg) + ACC_W'(pb_reg) + ACC_W'(1 << (FRAC_W - 1));

    always_ff @(posedge aclk) begin
        if (cmd.take_a) begin
            a_reg <= va_reg ? $signed(rd_data_reg) : '0;
        end
        if (cmd.take_b) begin
            b_reg <= vb_reg ? $signed(rd_data_reg) : '0;
        end
        if (cmd.calc_prod) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (cmd.commit) begin
            y_reg <= acc_next[FRAC_W +: SAMPLE_W];
        end
        if (cmd.load_out) begin
            out_reg <= byp_reg ? sample_reg : y_reg;
        end
    end

    assign m_sample_out = out_reg;

endmodule

`default_nettype wire

FILE: rtl/mfd_ctrl.sv
`default_nettype none

module mfd_ctrl
    import mfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  mfd_status_t status,
    output mfd_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PHASE = 4'd1;
    localparam logic [3:0] ST_SINE  = 4'd2;
    localparam logic [3:0] ST_LFO   = 4'd3;
    localparam logic [3:0] ST_TOTAL = 4'd4;
    localparam logic [3:0] ST_ADDR  = 4'd5;
    localparam logic [3:0] ST_RDA   = 4'd6;
    localparam logic [3:0] ST_RDB   = 4'd7;
    localparam logic [3:0] ST_TAKEB = 4'd8;
    localparam logic [3:0] ST_MUL   = 4'd9;
    localparam logic [3:0] ST_SUM   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = status.bypass ? ST_DONE : ST_PHASE;
                end
            end
            ST_PHASE: begin
                cmd.calc_sidx = 1'b1;
                state_next    = ST_SINE;
            end
            ST_SINE: begin
                cmd.read_sine = 1'b1;
                state_next    = ST_LFO;
            end
            ST_LFO: begin
                cmd.calc_lfo = 1'b1;
                state_next   = ST_TOTAL;
            end
            ST_TOTAL: begin
                cmd.calc_total = 1'b1;
                state_next     = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.calc_addr = 1'b1;
                state_next    = ST_RDA;
            end
            ST_RDA: begin
                state_next = ST_RDB;
            end
            ST_RDB: begin
                cmd.read_b = 1'b1;
                cmd.take_a = 1'b1;
                state_next = ST_TAKEB;
            end
            ST_TAKEB: begin
                cmd.take_b = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.calc_prod = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.load_out | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/modulated_fractional_delay.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_sample_in, s_channel
// m_        out        m_valid / m_ready    m_sample_out
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A modulated item passes the sine index, sine read, depth scaling, total and address steps,
// two reads through the single store read port, the interpolation multiplies and their sum.
// A bypassed item (delay below one sample) goes straight from capture to the output load.
// The next item is taken once the current one reaches the output register,
// even while that result still waits on m_ready.
// After reset the store reads as zero without a clearing pass: each channel's
// write pointer and a filled flag mark which slots hold samples.
`default_nettype none

`include "modulated_fractional_delay_defines.svh"

module modulated_fractional_delay
    import mfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 8192,
    parameter int CHANNELS     = 2,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic                       s_channel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    mfd_cmd_t    cmd;
    mfd_status_t status;
    logic        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    mfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mfd_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .CHANNELS     (CHANNELS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_sample_in  (s_sample_in),
        .s_channel    (s_channel),
        .cmd          (cmd),
        .status       (status),
        .m_sample_out (m_sample_out)
    );

    `MFD_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready, !s_ready)
    `MFD_ASSERT_NOW(a_no_overwrite, m_valid && !m_ready, !cmd.load_out)
    `MFD_ASSERT_NEXT(a_load_shows_result, cmd.load_out, m_valid)
    `MFD_ASSERT_NOW(a_commit_while_busy, cmd.commit, !s_ready && !cmd.load_out)

endmodule

`default_nettype wire

FILE: verif/modulated_fractional_delay_checker.sv
module modulated_fractional_delay_checker
    import mfd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic                       s_channel,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RING_LEN  = 8192;
    localparam int     LUT_LEN   = 1024;
    localparam int     PTR_W     = 13;
    localparam longint MAX_TOTAL = longint'(RING_LEN - 2) * 256;
    localparam longint Q30_ONE   = 64'sd1 << 30;

    logic signed [SINE_W-1:0]   sine_lut [LUT_LEN];
    logic signed [SAMPLE_W-1:0] ring [2][RING_LEN];
    logic [PTR_W-1:0]           wr_ptr [2];
    logic [PHASE_W-1:0]         lfo_phase [2];
    logic [DELAY_W-1:0]         base_delay;
    logic [DEPTH_W-1:0]         sweep_depth;
    logic [PHASE_W-1:0]         phase_inc;

    logic signed [SAMPLE_W-1:0] expected_taps [$];
    int n_taken = 0;
    int n_seen = 0;
    int miscount = 0;

    assign pending = n_taken - n_seen;

    // 32767*sin(2*pi*k/LUT_LEN) by a Q30 Taylor series, folded by quadrant
    function automatic logic signed [SINE_W-1:0] sine_q15(input int unsigned k);
        longint unsigned u, r, x, x2, term;
        longint sum, v;
        int unsigned quad;
        int n;
        u = (longint'(k) << 32) / LUT_LEN;
        quad = int'((u >> 30) & 3);
        r = u & (Q30_ONE - 1);
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * 32767 + (64'sd1 << 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        if (quad >= 2) begin
            v = -v;
        end
        return SINE_W'(v);
    endfunction

    // Interpolated tap for one sample; updates ring, pointer and phase unless bypassed.
    function automatic logic signed [SAMPLE_W-1:0] tap_sample(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic ch
    );
        logic [9:0]       sidx;
        logic [PTR_W-1:0] ptr, ia, ib;
        longint           lfo, total, acc;
        int unsigned      d, f;
        if (base_delay < 256) begin
            return smp;
        end
        sidx = lfo_phase[ch][PHASE_W-1 -: 10];
        lfo = (longint'(sweep_depth) * longint'(sine_lut[sidx])) >>> 15;
        total = longint'(base_delay) + lfo;
        if (total < 0) begin
            total = 0;
        end
        if (total > MAX_TOTAL) begin
            total = MAX_TOTAL;
        end
        d = int'(total >> 8);
        f = int'(total & 255);
        ptr = wr_ptr[ch];
        ia = ptr - PTR_W'(d);
        ib = ptr - PTR_W'(d) - 1'b1;
        acc = longint'(256 - f) * longint'(ring[ch][ia])
            + longint'(f) * longint'(ring[ch][ib]) + 128;
        ring[ch][ptr] = smp;
        wr_ptr[ch] = ptr + 1'b1;
        lfo_phase[ch] = lfo_phase[ch] + phase_inc;
        return SAMPLE_W'(acc >>> 8);
    endfunction

    initial begin
        for (int k = 0; k < LUT_LEN; k++) begin
            sine_lut[k] = sine_q15(k);
        end
    end

    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] want;
        int c, i;
        if (!aresetn) begin
            for (c = 0; c < 2; c++) begin
                for (i = 0; i < RING_LEN; i++) begin
                    ring[c][i] = '0;
                end
                wr_ptr[c] = '0;
                lfo_phase[c] = '0;
            end
            base_delay = '0;
            sweep_depth = '0;
            phase_inc = '0;
            expected_taps.delete();
            n_taken <= 0;
            n_seen <= 0;
        end else begin
            // compare before predicting: a result never leaves in its own transfer cycle
            if (m_valid && m_ready) begin
                if (expected_taps.size() == 0) begin
                    miscount++;
                    if (miscount <= 10) begin
                        $display("unexpected sample_out %0d at %0t", m_sample_out, $realtime);
                    end
                end else begin
                    want = expected_taps.pop_front();
                    n_seen <= n_seen + 1;
                    if (m_sample_out !== want) begin
                        miscount++;
                        if (miscount <= 10) begin
                            $display("sample_out mismatch at %0t: expected %0d, got %0d",
                                     $realtime, want, m_sample_out);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DELAY: base_delay = cfg_data[DELAY_W-1:0];
                    REG_DEPTH: sweep_depth = cfg_data[DEPTH_W-1:0];
                    REG_STEP:  phase_inc = cfg_data[PHASE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_taps.push_back(tap_sample(s_sample_in, s_channel));
                n_taken <= n_taken + 1;
            end
            fail_count <= miscount;
        end
    end

endmodule

FILE: verif/tb_modulated_fractional_delay.sv
module tb_modulated_fractional_delay;
    import mfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0]  REG_SPARE  = 2'd3;
    localparam logic [DELAY_W-1:0]    DELAY_MAX  = 21'd2096640;
    localparam logic [DEPTH_W-1:0]    DEPTH_MAX  = '1;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in = '0;
    logic                       s_channel = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    int fail_count;
    int pending;
    int tx_idle_pct = 11;
    int rx_idle_pct = 76;
    int items_sent = 0;
    int cycle_count = 0;

    modulated_fractional_delay dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .s_channel    (s_channel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    modulated_fractional_delay_checker tap_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .s_channel    (s_channel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(15))
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Leaves s_valid high after the transfer so back-to-back items need no toggle.
    task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic ch);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_sample_in <= smp;
        s_channel <= ch;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Hold off until every transfer has its result, then let the pipeline drain.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Random upper bits go with the delay and depth writes; only the register width counts.
    task automatic configure(input int unsigned delay, input int unsigned depth,
                             input logic [PHASE_W-1:0] step);
        settle();
        write_reg(REG_DELAY, ($urandom & ~32'h001F_FFFF) | delay);
        write_reg(REG_DEPTH, ($urandom & ~32'h0003_FFFF) | depth);
        write_reg(REG_STEP, step);
        write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_segment(input int n);
        int unsigned mode, delay, depth;
        logic [PHASE_W-1:0] step;
        mode = $urandom_range(9);
        step = $urandom_range(1) ? $urandom : $urandom_range(32'h0400_0000);
        if (mode == 0) begin
            delay = $urandom_range(255);
            depth = $urandom & 32'h3_FFFF;
        end else if (mode == 1) begin
            delay = $urandom_range(DELAY_MAX, 256);
            depth = $urandom & 32'h3_FFFF;
        end else begin
            // short delays keep reads on samples written in this run
            delay = $urandom_range(64 * 256, 256);
            depth = (mode == 2) ? ($urandom & 32'h3_FFFF) : $urandom_range(delay);
        end
        configure(delay, depth, step);
        repeat (n) send_item(rand_sample(), 1'($urandom_range(1)));
    endtask

    task automatic random_stage(input int stage_end);
        while (items_sent < stage_end) begin
            random_segment($urandom_range(90, 20));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // delay register at reset value: pass-through
        send_item(SMP_MIN, 1'b0);
        send_item(SMP_MAX, 1'b1);
        send_item('0, 1'b0);
        send_item(-1, 1'b1);

        // one whole sample of delay
        configure(256, 0, 0);
        send_item(SMP_MAX, 1'b0);
        send_item(SMP_MIN, 1'b0);
        send_item(5, 1'b1);
        send_item(SMP_MIN, 1'b0);

        // half-sample interpolation, rounding on negative values
        configure(384, 0, 0);
        send_item(-3, 1'b0);
        send_item(7, 1'b0);
        send_item(-1, 1'b0);

        // three-quarter phase steps drive the total below zero: zero distance
        configure(256, DEPTH_MAX, 32'hC000_0000);
        repeat (4) send_item(rand_sample(), 1'b0);

        // longest delay with the sweep pushing past the top clamp
        configure(DELAY_MAX, DEPTH_MAX, 32'h4000_0000);
        repeat (3) send_item(rand_sample(), 1'b1);

        // just under one sample: pass-through, phase must hold
        configure(255, DEPTH_MAX, 1);
        send_item(rand_sample(), 1'b0);
        send_item(rand_sample(), 1'b1);

        configure(DELAY_MAX, 0, 32'hFFFF_FFFF);
        send_item(rand_sample(), 1'b0);
        send_item(rand_sample(), 1'b1);

        random_stage(items_sent + 650);
        tx_idle_pct = 76;
        rx_idle_pct = 11;
        random_stage(items_sent + 650);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_stage(items_sent + 650);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: modulated_fractional_delay.f
+incdir+rtl
rtl/mfd_pkg.sv
rtl/mfd_datapath.sv
rtl/mfd_ctrl.sv
rtl/modulated_fractional_delay.sv
verif/modulated_fractional_delay_checker.sv
verif/tb_modulated_fractional_delay.sv
